// ===== hw/rtl/stx_etx_length_frame_parser_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the frame parser checker
// ---------------------------------------------------------------------------
`ifndef STX_ETX_LENGTH_FRAME_PARSER_ASSERT_SVH
`define STX_ETX_LENGTH_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SETLFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SETLFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/setlfp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// setlfp_pkg
// Types and codes shared by the STX/ETX length frame parser.
// ---------------------------------------------------------------------------
package setlfp_pkg;

    localparam logic [7:0] CHR_CR = 8'd13;
    localparam logic [7:0] CHR_LF = 8'd10;

    // Result event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_CHAR   = 2'd1;
    localparam logic [1:0] EV_ACCEPT = 2'd2;
    localparam logic [1:0] EV_DROP   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_COMMAND = 2'd1;
    localparam logic [1:0] CFG_END     = 2'd2;
    localparam logic [1:0] CFG_CRLF    = 2'd3;

    // CR/LF tracking codes
    localparam logic [1:0] CRLF_NONE = 2'd0;
    localparam logic [1:0] CRLF_CR   = 2'd1;
    localparam logic [1:0] CRLF_BOTH = 2'd2;

    typedef enum logic [3:0] {
        STG_HUNT = 4'b0001,
        STG_CMD  = 4'b0010,
        STG_DATA = 4'b0100,
        STG_END  = 4'b1000
    } stage_t;

    typedef struct packed {
        stage_t     stage;
        logic [8:0] byte_count;
        logic [7:0] declared_length;
        logic [1:0] crlf_progress;
    } frame_state_t;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] command_code;
        logic [7:0] end_code;
        logic       crlf_mode;
    } frame_cfg_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] char_value;
        logic [7:0] char_index;
        logic [7:0] frame_length;
    } frame_result_t;

    localparam frame_state_t STATE_CLEAR = '{
        stage:           STG_HUNT,
        byte_count:      9'd0,
        declared_length: 8'd0,
        crlf_progress:   CRLF_NONE
    };

endpackage

// ===== hw/rtl/setlfp_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// setlfp_step
// Per-byte parser update: next frame state and the result word for one byte.
// ---------------------------------------------------------------------------
module setlfp_step
(
    input  setlfp_pkg::frame_cfg_t    cfg,
    input  setlfp_pkg::frame_state_t  cur,
    input  logic [7:0]                rx_byte,
    output setlfp_pkg::frame_state_t  nxt,
    output setlfp_pkg::frame_result_t res
);

    logic [8:0] cnt;
    logic [7:0] len_now;
    logic [8:0] lim;
    logic [8:0] lim_m1;
    logic       bad;
    logic       done;
    logic [8:0] idx_full;

    always_comb
    begin
        cnt      = cur.byte_count + 9'd1;
        len_now  = (cnt == 9'd2) ? rx_byte : cur.declared_length;
        lim      = {1'b0, len_now} + 9'd2;
        lim_m1   = lim - 9'd1;
        idx_full = cnt - 9'd3;
        bad      = 1'b0;
        done     = 1'b0;

        nxt = cur;
        res.event_res    = setlfp_pkg::EV_NONE;
        res.char_value   = 8'd0;
        res.char_index   = 8'd0;
        res.frame_length = cur.declared_length;

        unique case (cur.stage)
            setlfp_pkg::STG_HUNT:
            begin
                if (rx_byte == cfg.start_code)
                begin
                    nxt.stage = setlfp_pkg::STG_CMD;
                end
            end
            setlfp_pkg::STG_CMD:
            begin
                if (rx_byte == cfg.command_code)
                begin
                    nxt.stage      = setlfp_pkg::STG_DATA;
                    nxt.byte_count = 9'd1;
                end
                else
                begin
                    res.event_res = setlfp_pkg::EV_DROP;
                    nxt           = setlfp_pkg::STATE_CLEAR;
                end
            end
            setlfp_pkg::STG_DATA:
            begin
                nxt.byte_count      = cnt;
                nxt.declared_length = len_now;
                res.frame_length    = len_now;
                if (cfg.crlf_mode)
                begin
                    // CR must be second to last, LF last
                    if (cnt == lim_m1)
                    begin
                        if (rx_byte == setlfp_pkg::CHR_CR
                            && cur.crlf_progress == setlfp_pkg::CRLF_NONE)
                        begin
                            nxt.crlf_progress = setlfp_pkg::CRLF_CR;
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                    end
                    if (!bad && cnt == lim)
                    begin
                        if (rx_byte == setlfp_pkg::CHR_LF
                            && cur.crlf_progress == setlfp_pkg::CRLF_CR)
                        begin
                            nxt.crlf_progress = setlfp_pkg::CRLF_BOTH;
                            done              = 1'b1;
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                    end
                end
                else if (cnt == lim)
                begin
                    done = 1'b1;
                end
                if (cnt > lim)
                begin
                    bad = 1'b1;
                end

                if (bad)
                begin
                    res.event_res = setlfp_pkg::EV_DROP;
                    nxt           = setlfp_pkg::STATE_CLEAR;
                end
                else
                begin
                    // command and length bytes are counted but not streamed
                    if (cnt >= 9'd3)
                    begin
                        res.event_res  = setlfp_pkg::EV_CHAR;
                        res.char_value = rx_byte;
                        res.char_index = idx_full[7:0];
                    end
                    if (done)
                    begin
                        nxt.stage = setlfp_pkg::STG_END;
                    end
                end
            end
            setlfp_pkg::STG_END:
            begin
                if (rx_byte == cfg.end_code
                    && (!cfg.crlf_mode || cur.crlf_progress == setlfp_pkg::CRLF_BOTH))
                begin
                    res.event_res = setlfp_pkg::EV_ACCEPT;
                end
                else
                begin
                    res.event_res = setlfp_pkg::EV_DROP;
                end
                nxt = setlfp_pkg::STATE_CLEAR;
            end
            default:
            begin
                nxt = setlfp_pkg::STATE_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/stx_etx_length_frame_parser.sv =====
`timescale 1ns / 1ps
// A byte passes from the input register through the step logic to the result
// register. One byte per cycle while out_stall is low; the input and result
// registers form a two-word pipeline: a new byte is taken while a result waits.
// Reset (rst_n low, asynchronous): parser hunts for the start byte, frame
// state cleared, registers back to start 2, command 0, end 3, CR/LF mode off.
// ---------------------------------------------------------------------------
// stx_etx_length_frame_parser
// Finds start/command/length/characters/end frames in a byte stream and
// emits one result word per received byte.
// ---------------------------------------------------------------------------
module stx_etx_length_frame_parser
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_res,
    output logic [7:0] char_value,
    output logic [7:0] char_index,
    output logic [7:0] frame_length
);

    setlfp_pkg::frame_cfg_t    cfg_reg;
    setlfp_pkg::frame_state_t  state_reg;
    setlfp_pkg::frame_state_t  state_next;
    setlfp_pkg::frame_result_t res_next;
    setlfp_pkg::frame_result_t res_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_load;

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code   <= 8'd2;
            cfg_reg.command_code <= 8'd0;
            cfg_reg.end_code     <= 8'd3;
            cfg_reg.crlf_mode    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                setlfp_pkg::CFG_START:   cfg_reg.start_code   <= cfg_data;
                setlfp_pkg::CFG_COMMAND: cfg_reg.command_code <= cfg_data;
                setlfp_pkg::CFG_END:     cfg_reg.end_code     <= cfg_data;
                setlfp_pkg::CFG_CRLF:    cfg_reg.crlf_mode    <= cfg_data[0];
                default:                 cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    setlfp_step u_step
    (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .rx_byte (in_byte_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    // advance frame state only when the word moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= setlfp_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = res_reg.event_res;
    assign char_value   = res_reg.char_value;
    assign char_index   = res_reg.char_index;
    assign frame_length = res_reg.frame_length;

endmodule

// ===== hw/rtl/setlfp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// setlfp_checker
// Port-level checks on the frame parser byte and result channels.
// ---------------------------------------------------------------------------
`include "stx_etx_length_frame_parser_assert.svh"

module setlfp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] event_res,
    input logic [7:0] char_value,
    input logic [7:0] char_index,
    input logic [7:0] frame_length
);

    logic [25:0] out_word;
    logic        in_wait;
    logic        out_wait;
    logic        char_event;
    logic        char_clear;

    assign out_word   = {event_res, char_value, char_index, frame_length};
    assign in_wait    = in_valid && in_stall;
    assign out_wait   = out_valid && out_stall;
    assign char_event = out_valid && (event_res == setlfp_pkg::EV_CHAR);
    assign char_clear = (char_value == 8'd0) && (char_index == 8'd0);

    // hold a stalled byte word
    `SETLFP_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(rx_byte), "input word changed")

    // hold a stalled result word
    `SETLFP_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_word), "result changed")

    // character fields are zero unless a character is reported
    `SETLFP_ASSERT_NOW(a_char_zero, out_valid && !char_event, char_clear, "stray char fields")

    // a streamed character lies inside the declared length
    `SETLFP_ASSERT_NOW(a_char_in_frame, char_event, char_index < frame_length, "index past length")

endmodule

bind stx_etx_length_frame_parser setlfp_checker u_setlfp_checker (.*);
